// File: sv/asrs_pkg.sv
`timescale 1ns / 1ps

package asrs_pkg;

   typedef struct packed {
      logic [47:0] sector_base;
      logic [31:0] byte_offset;
      logic [31:0] byte_length;
      logic        write_request;
      logic        data_ok;
   } req_type;

   typedef struct packed {
      logic       item_kind;
      logic [2:0] reg_index;
      logic [7:0] reg_data;
      logic [9:0] bytes_done;
      logic [8:0] copy_start;
      logic       from_saved;
      logic       last_item;
   } rsp_type;

   typedef struct packed {
      logic lba48;
      logic buffered;
   } cfg_type;

   // one classified request, handed from front to back
   typedef struct packed {
      logic        issue;
      logic        lba48;
      logic        write_cmd;
      logic [47:0] lba;
      logic [8:0]  count;
      logic [9:0]  bytes_done;
      logic [8:0]  copy_start;
      logic        from_saved;
   } desc_type;

   localparam logic KIND_REG  = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [2:0] TF_REG_COUNT   = 3'd2;
   localparam logic [2:0] TF_REG_LBA_LOW = 3'd3;
   localparam logic [2:0] TF_REG_LBA_MID = 3'd4;
   localparam logic [2:0] TF_REG_LBA_HI  = 3'd5;
   localparam logic [2:0] TF_REG_DEVICE  = 3'd6;
   localparam logic [2:0] TF_REG_COMMAND = 3'd7;

   localparam logic [7:0] DEV_LBA28     = 8'hE0;
   localparam logic [7:0] DEV_LBA48     = 8'h40;
   localparam logic [7:0] CMD_READ      = 8'h20;
   localparam logic [7:0] CMD_WRITE     = 8'h30;
   localparam logic [7:0] CMD_READ_EXT  = 8'h24;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

   localparam logic [9:0] SECTOR_BYTES = 10'd512;
   localparam logic [8:0] RUN_MAX      = 9'd256;

   localparam logic CSR_LBA48    = 1'b0;
   localparam logic CSR_BUFFERED = 1'b1;

endpackage

// File: sv/asrs_queue.sv
`timescale 1ns / 1ps

module asrs_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  asrs_pkg::desc_type push_data,
   output logic               full,
   input  logic               pop,
   output asrs_pkg::desc_type pop_data,
   output logic               valid
);
   import asrs_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/asrs_front.sv
`timescale 1ns / 1ps

module asrs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  asrs_pkg::req_type  req_item,
   input  asrs_pkg::cfg_type  cfg,
   input  logic               q_full,
   output logic               q_push,
   output asrs_pkg::desc_type q_data
);
   import asrs_pkg::*;

   logic [47:0] saved_sector_ff, saved_sector_in;
   logic        saved_valid_ff, saved_valid_in;
   logic [47:0] expected_sector_ff, expected_sector_in;
   logic        expected_valid_ff, expected_valid_in;
   logic [8:0]  run_remaining_ff, run_remaining_in;

   logic        accept;
   logic [47:0] sector_step;
   logic [47:0] lba;
   logic [47:0] lba_next;
   logic [8:0]  start;
   logic [33:0] run_sum;
   logic [24:0] run_sectors;
   logic [8:0]  run_len;
   logic [9:0]  room;
   logic [9:0]  nbytes;
   logic        saved_hit;
   logic        new_cmd;
   logic [8:0]  run_pick;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;

   always_comb begin
      sector_step = {25'd0, req_item.byte_offset[31:9]};
      lba         = req_item.sector_base + sector_step;
      lba_next    = req_item.sector_base + sector_step + 48'd1;
      start       = req_item.byte_offset[8:0];
      run_sum     = {2'b00, req_item.byte_length} + 34'd511 + {25'd0, start};
      run_sectors = run_sum[33:9];
      run_len     = (run_sectors > 25'd256) ? RUN_MAX : run_sectors[8:0];
      room        = SECTOR_BYTES - {1'b0, start};
      nbytes      = (req_item.byte_length < {22'd0, room}) ?
                    req_item.byte_length[9:0] : room;
      saved_hit   = saved_valid_ff && (saved_sector_ff == lba);
      new_cmd     = !expected_valid_ff || (expected_sector_ff != lba) ||
                    (run_remaining_ff == 9'd0);
      run_pick    = new_cmd ? run_len : run_remaining_ff;
   end

   always_comb begin
      saved_sector_in    = saved_sector_ff;
      saved_valid_in     = saved_valid_ff;
      expected_sector_in = expected_sector_ff;
      expected_valid_in  = expected_valid_ff;
      run_remaining_in   = run_remaining_ff;

      q_data            = '0;
      q_data.lba48      = cfg.lba48;
      q_data.write_cmd  = req_item.write_request;
      q_data.lba        = lba;
      q_data.count      = run_len;

      if (req_item.write_request) begin
         q_data.issue      = 1'b1;
         q_data.count      = 9'd1;
         q_data.bytes_done = req_item.data_ok ? SECTOR_BYTES : 10'd0;
         if (accept) begin
            if (saved_hit) begin
               saved_valid_in = 1'b0;
            end
            run_remaining_in = 9'd0;
         end
      end else if (saved_hit) begin
         q_data.bytes_done = nbytes;
         q_data.copy_start = start;
         q_data.from_saved = 1'b1;
      end else begin
         q_data.issue = new_cmd;
         if (req_item.data_ok) begin
            q_data.bytes_done = nbytes;
            q_data.copy_start = start;
         end
         if (accept) begin
            if (!req_item.data_ok) begin
               run_remaining_in = 9'd0;
            end else begin
               if ((nbytes != SECTOR_BYTES) || cfg.buffered) begin
                  saved_sector_in = lba;
                  saved_valid_in  = 1'b1;
               end
               expected_sector_in = lba_next;
               expected_valid_in  = 1'b1;
               run_remaining_in   = (run_pick != 9'd0) ? run_pick - 9'd1 : 9'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_sector_ff    <= '0;
         saved_valid_ff     <= 1'b0;
         expected_sector_ff <= '0;
         expected_valid_ff  <= 1'b0;
         run_remaining_ff   <= '0;
      end else begin
         saved_sector_ff    <= saved_sector_in;
         saved_valid_ff     <= saved_valid_in;
         expected_sector_ff <= expected_sector_in;
         expected_valid_ff  <= expected_valid_in;
         run_remaining_ff   <= run_remaining_in;
      end
   end

endmodule

// File: sv/asrs_back.sv
`timescale 1ns / 1ps

module asrs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  asrs_pkg::desc_type q_data,
   output logic               q_pop,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output asrs_pkg::rsp_type  rsp_item
);
   import asrs_pkg::*;

   typedef enum logic [10:0] {
      ST_DEV  = 11'b000_0000_0001,
      ST_X47  = 11'b000_0000_0010,
      ST_X39  = 11'b000_0000_0100,
      ST_X31  = 11'b000_0000_1000,
      ST_XCNT = 11'b000_0001_0000,
      ST_L23  = 11'b000_0010_0000,
      ST_L15  = 11'b000_0100_0000,
      ST_L7   = 11'b000_1000_0000,
      ST_CNT  = 11'b001_0000_0000,
      ST_CMD  = 11'b010_0000_0000,
      ST_DONE = 11'b100_0000_0000
   } step_type;

   step_type step_ff, step_in, step_next;
   logic     busy_ff, busy_in;
   logic     rsp_valid_ff, rsp_valid_in;
   desc_type desc_ff, desc_in;
   rsp_type  rsp_item_ff, rsp_item_in;
   rsp_type  item;

   logic out_ready;
   logic emit;
   logic at_done;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_ready;
   assign at_done   = (step_ff == ST_DONE);
   assign q_pop     = q_valid && (!busy_ff || (emit && at_done));
   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      unique case (step_ff)
         ST_DEV:  step_next = desc_ff.lba48 ? ST_X47 : ST_L23;
         ST_X47:  step_next = ST_X39;
         ST_X39:  step_next = ST_X31;
         ST_X31:  step_next = ST_XCNT;
         ST_XCNT: step_next = ST_L23;
         ST_L23:  step_next = ST_L15;
         ST_L15:  step_next = ST_L7;
         ST_L7:   step_next = ST_CNT;
         ST_CNT:  step_next = ST_CMD;
         ST_CMD:  step_next = ST_DONE;
         ST_DONE: step_next = ST_DONE;
         default: step_next = ST_DONE;
      endcase
   end

   always_comb begin
      item           = '0;
      item.item_kind = KIND_REG;
      unique case (step_ff)
         ST_DEV: begin
            item.reg_index = TF_REG_DEVICE;
            item.reg_data  = desc_ff.lba48 ? DEV_LBA48 :
                             (DEV_LBA28 | {4'd0, desc_ff.lba[27:24]});
         end
         ST_X47: begin
            item.reg_index = TF_REG_LBA_HI;
            item.reg_data  = desc_ff.lba[47:40];
         end
         ST_X39: begin
            item.reg_index = TF_REG_LBA_MID;
            item.reg_data  = desc_ff.lba[39:32];
         end
         ST_X31: begin
            item.reg_index = TF_REG_LBA_LOW;
            item.reg_data  = desc_ff.lba[31:24];
         end
         ST_XCNT: begin
            item.reg_index = TF_REG_COUNT;
            item.reg_data  = {7'd0, desc_ff.count[8]};
         end
         ST_L23: begin
            item.reg_index = TF_REG_LBA_HI;
            item.reg_data  = desc_ff.lba[23:16];
         end
         ST_L15: begin
            item.reg_index = TF_REG_LBA_MID;
            item.reg_data  = desc_ff.lba[15:8];
         end
         ST_L7: begin
            item.reg_index = TF_REG_LBA_LOW;
            item.reg_data  = desc_ff.lba[7:0];
         end
         ST_CNT: begin
            item.reg_index = TF_REG_COUNT;
            item.reg_data  = desc_ff.count[7:0];
         end
         ST_CMD: begin
            item.reg_index = TF_REG_COMMAND;
            if (desc_ff.lba48) begin
               item.reg_data = desc_ff.write_cmd ? CMD_WRITE_EXT : CMD_READ_EXT;
            end else begin
               item.reg_data = desc_ff.write_cmd ? CMD_WRITE : CMD_READ;
            end
         end
         ST_DONE: begin
            item.item_kind  = KIND_DONE;
            item.bytes_done = desc_ff.bytes_done;
            item.copy_start = desc_ff.copy_start;
            item.from_saved = desc_ff.from_saved;
            item.last_item  = 1'b1;
         end
         default: begin
            item = '0;
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         desc_in = q_data;
         step_in = q_data.issue ? ST_DEV : ST_DONE;
      end else if (emit && at_done) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_next;
      end
      if (out_ready) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_item_in = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// File: sv/ata_sector_request_sequencer_unit.sv
`timescale 1ns / 1ps

// ATA sector request sequencer.
// req_*: one sector request per item (base LBA, byte offset, length, write
//   flag, data phase outcome). Taken when req_valid is high and req_stall low.
// rsp_*: result items, one per cycle when not stalled. A request gives
//   one completion item (last_item set), preceded by the taskfile register
//   writes when a new command is needed: 6 in LBA28 mode, 10 in LBA48 mode.
//   So a request gives 1, 7 or 11 result items.
// csr_*: register writes (index 0 LBA48 mode, index 1 buffered mode); always
//   ready. Write only while the block is idle.
// The front classifies a request and updates the saved/expected sector state
// in the cycle it is taken, then queues it. The back walks the taskfile
// sequence one register per cycle, when not stalled, into an output register.
// A request passes through the queue, the back's descriptor register and then the output register.
// The front keeps taking requests while the queue has room, so req_stall
// rises only when QUEUE_DEPTH requests wait behind the one being emitted.
// rsp_stall holds the output register and pauses the back.
// Reset clears the sector state, the queue, the config and rsp_valid.
module ata_sector_request_sequencer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asrs_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output asrs_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic              csr_data
);
   import asrs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   logic     back_busy;
   desc_type q_push_data;
   desc_type q_pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LBA48:    cfg_in.lba48    = csr_data;
            CSR_BUFFERED: cfg_in.buffered = csr_data;
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   asrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .valid     (q_valid)
   );

   asrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .busy      (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   a_no_valid_after_reset: assert property (
      @(posedge clock) $past(reset) |-> !rsp_valid
   ) else $error("result valid right after reset");

   a_idle_back_pulls: assert property (
      @(posedge clock) disable iff (reset)
      (q_valid && !back_busy) |-> q_pop
   ) else $error("back idle while queue holds a request");

   a_reg_write_fields: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.item_kind == KIND_REG)) |->
      ((rsp_item.bytes_done == 10'd0) && !rsp_item.last_item && !rsp_item.from_saved)
   ) else $error("register write item carries completion fields");

   a_done_is_last: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.item_kind == KIND_DONE)) |->
      (rsp_item.last_item && (rsp_item.reg_index == 3'd0))
   ) else $error("completion item malformed");

endmodule

// File: bench/tb_ata_sector_request_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_ata_sector_request_sequencer_unit;
   import asrs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_index = 1'b0;
   logic    csr_data = 1'b0;

   ata_sector_request_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state
   logic        cfg_lba48 = 1'b0;
   logic        cfg_buffered = 1'b0;
   logic [47:0] buf_lba = '0;
   logic        buf_valid = 1'b0;
   logic [47:0] next_lba = '0;
   logic        next_valid = 1'b0;
   logic [8:0]  run_left = '0;
   rsp_type     ata_items_due[$];
   int          items_due_count = 0;
   int          errors = 0;

   int          send_idle_pct = 0;
   int          rcv_idle_pct = 0;
   logic        hold_arm = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   logic [47:0] gen_last = '0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   function automatic void push_reg_write(logic [2:0] idx, logic [7:0] data);
      rsp_type r;
      r = '0;
      r.item_kind = KIND_REG;
      r.reg_index = idx;
      r.reg_data = data;
      ata_items_due.push_back(r);
   endfunction

   function automatic void push_completion(logic [9:0] nbytes, logic [8:0] start,
                                           logic saved);
      rsp_type r;
      r = '0;
      r.item_kind = KIND_DONE;
      r.bytes_done = nbytes;
      r.copy_start = start;
      r.from_saved = saved;
      r.last_item = 1'b1;
      ata_items_due.push_back(r);
   endfunction

   function automatic void push_taskfile(logic [47:0] lba, logic [8:0] count, logic wr);
      logic [7:0] cmd;
      if (cfg_lba48) begin
         push_reg_write(TF_REG_DEVICE, DEV_LBA48);
         push_reg_write(TF_REG_LBA_HI, lba[47:40]);
         push_reg_write(TF_REG_LBA_MID, lba[39:32]);
         push_reg_write(TF_REG_LBA_LOW, lba[31:24]);
         push_reg_write(TF_REG_COUNT, {7'b0, count[8]});
         cmd = wr ? CMD_WRITE_EXT : CMD_READ_EXT;
      end else begin
         push_reg_write(TF_REG_DEVICE, DEV_LBA28 | {4'b0, lba[27:24]});
         cmd = wr ? CMD_WRITE : CMD_READ;
      end
      push_reg_write(TF_REG_LBA_HI, lba[23:16]);
      push_reg_write(TF_REG_LBA_MID, lba[15:8]);
      push_reg_write(TF_REG_LBA_LOW, lba[7:0]);
      push_reg_write(TF_REG_COUNT, count[7:0]);
      push_reg_write(TF_REG_COMMAND, cmd);
   endfunction

   function automatic void plan_ata_items(req_type r);
      logic [47:0] lba;
      logic [8:0]  start;
      logic [33:0] span;
      logic [8:0]  run;
      logic [9:0]  nbytes;
      lba = r.sector_base + 48'(r.byte_offset[31:9]);
      start = r.byte_offset[8:0];
      span = ({2'b0, r.byte_length} + 34'd511 + 34'(start)) >> 9;
      run = (span > 34'd256) ? RUN_MAX : span[8:0];
      nbytes = SECTOR_BYTES - 10'(start);
      if (r.byte_length < 32'(nbytes)) nbytes = r.byte_length[9:0];
      if (r.write_request) begin
         if (buf_valid && buf_lba == lba) buf_valid = 1'b0;
         run_left = '0;
         push_taskfile(lba, 9'd1, 1'b1);
         push_completion(r.data_ok ? SECTOR_BYTES : 10'd0, 9'd0, 1'b0);
         return;
      end
      if (buf_valid && buf_lba == lba) begin
         push_completion(nbytes, start, 1'b1);
         return;
      end
      if (!next_valid || next_lba != lba || run_left == 0) begin
         run_left = run;
         push_taskfile(lba, run, 1'b0);
      end
      if (!r.data_ok) begin
         run_left = '0;
         push_completion(10'd0, 9'd0, 1'b0);
         return;
      end
      if (nbytes < SECTOR_BYTES || cfg_buffered) begin
         buf_lba = lba;
         buf_valid = 1'b1;
      end
      next_lba = lba + 48'd1;
      next_valid = 1'b1;
      if (run_left != 0) run_left = run_left - 9'd1;
      push_completion(nbytes, start, 1'b0);
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // request tracking and result checking
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && req_valid && !req_stall) plan_ata_items(req_item);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ata_items_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected item expected none actual %h", $time, rsp_item);
         end else begin
            want = ata_items_due.pop_front();
            check_field("item_kind", want.item_kind, rsp_item.item_kind);
            check_field("reg_index", want.reg_index, rsp_item.reg_index);
            check_field("reg_data", want.reg_data, rsp_item.reg_data);
            check_field("bytes_done", want.bytes_done, rsp_item.bytes_done);
            check_field("copy_start", want.copy_start, rsp_item.copy_start);
            check_field("from_saved", want.from_saved, rsp_item.from_saved);
            check_field("last_item", want.last_item, rsp_item.last_item);
         end
      end
      items_due_count <= ata_items_due.size();
   end

   // receiver stalls, with an occasional long hold
   always @(posedge clock) begin
      if (hold_arm != hold_seen) begin
         hold_seen <= hold_arm;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
   end

   function automatic req_type mk(logic [47:0] base, logic [31:0] off, logic [31:0] len,
                                  logic wr, logic ok);
      req_type r;
      r.sector_base = base;
      r.byte_offset = off;
      r.byte_length = len;
      r.write_request = wr;
      r.data_ok = ok;
      return r;
   endfunction

   function automatic logic [31:0] gen_length();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd512;
         2, 3: return 32'($urandom_range(600, 1));
         4: return 32'($urandom_range(8, 1)) * 32'd512;
         5: return 32'($urandom_range(256 * 512 + 1200, 256 * 512 - 600));
         6: return $urandom();
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // mostly run continuations and rereads, some writes, some scattered
   function automatic req_type gen_request();
      req_type     r;
      int          pick;
      logic [47:0] tgt;
      logic [22:0] k;
      logic [8:0]  start;
      pick = $urandom_range(99);
      r.byte_length = gen_length();
      r.write_request = 1'b0;
      r.data_ok = ($urandom_range(99) < 90);
      if (pick < 45) begin
         tgt = gen_last + 48'd1;
      end else if (pick < 60) begin
         tgt = gen_last;
      end else if (pick < 72) begin
         tgt = gen_last + 48'($urandom_range(1));
         r.write_request = 1'b1;
      end else begin
         r.write_request = ($urandom_range(9) == 0);
         if ($urandom_range(3) == 0) begin
            r.sector_base = {16'($urandom()), $urandom()};
            r.byte_offset = $urandom();
            gen_last = r.sector_base + 48'(r.byte_offset[31:9]);
            return r;
         end
         tgt = $urandom_range(1) ? {16'($urandom()), $urandom()}
                                 : 48'hFFFF_FFFF_FFFF - 48'($urandom_range(3));
      end
      start = $urandom_range(1) ? 9'd0 : 9'($urandom_range(511));
      k = ($urandom_range(3) == 0) ? 23'($urandom()) : 23'($urandom_range(7));
      r.byte_offset = {k, start};
      r.sector_base = tgt - 48'(k);
      gen_last = tgt;
      return r;
   endfunction

   task automatic send_req(req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (items_due_count != 0);
   endtask

   task automatic write_csr(logic idx, logic val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LBA48) cfg_lba48 = val;
      else cfg_buffered = val;
      @(posedge clock);
   endtask

   task automatic test_directed_lba28();
      write_csr(CSR_LBA48, 1'b0);
      write_csr(CSR_BUFFERED, 1'b0);
      send_idle_pct = 0;
      rcv_idle_pct <= 30;
      send_req(mk(48'd0, 32'd0, 32'd0, 1'b0, 1'b1));          // zero length
      send_req(mk(48'd0, 32'd512, 32'd512, 1'b0, 1'b1));
      send_req(mk(48'd0, 32'd1024, 32'd600, 1'b0, 1'b1));
      send_req(mk(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1)); // wrap
      send_req(mk(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 1'b0, 1'b1));         // saved hit
      send_req(mk(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1));         // write
      send_req(mk(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd9, 1'b0, 1'b0));         // read error
      send_req(mk(48'h0F00_0000, 32'd0, 32'd131072, 1'b0, 1'b1));                 // run 256
      send_req(mk(48'h0F00_0001, 32'd0, 32'd512, 1'b0, 1'b1));
      send_req(mk(48'h0F00_0002, 32'd100, 32'd20, 1'b0, 1'b1));
      send_req(mk(48'd5, 32'd0, 32'd0, 1'b1, 1'b0));                               // write fail
      send_req(mk(48'h0F00_0003, 32'd0, 32'd512, 1'b0, 1'b1));
      wait_drained();
   endtask

   task automatic test_directed_lba48();
      write_csr(CSR_LBA48, 1'b1);
      write_csr(CSR_BUFFERED, 1'b1);
      send_req(mk(48'hA5A5_5A5A_C3C3, 32'd0, 32'd131072, 1'b0, 1'b1));
      send_req(mk(48'hA5A5_5A5A_C3C4, 32'd0, 32'd512, 1'b0, 1'b1));
      send_req(mk(48'hA5A5_5A5A_C3C4, 32'd0, 32'd512, 1'b0, 1'b1));
      send_req(mk(48'h8000_0000_0000, 32'd0, 32'd1, 1'b1, 1'b1));
      send_req(mk(48'h1234_5678_9ABC, 32'h1FF, 32'd1, 1'b0, 1'b0));
      send_req(mk(48'hFFFF_FFFF_FFFF, 32'h200, 32'd3, 1'b0, 1'b1));
      send_req(mk(48'd7, 32'd0, 32'd0, 1'b0, 1'b1));
      wait_drained();
   endtask

   task automatic test_random_mix(int count, logic lba48, logic buffered,
                                  int send_pct, int rcv_pct);
      write_csr(CSR_LBA48, lba48);
      write_csr(CSR_BUFFERED, buffered);
      send_idle_pct = send_pct;
      rcv_idle_pct <= rcv_pct;
      repeat (count) send_req(gen_request());
      wait_drained();
   endtask

   // receiver holds off so the queue fills and req_stall rises
   task automatic test_backpressure();
      write_csr(CSR_LBA48, 1'b0);
      write_csr(CSR_BUFFERED, 1'b1);
      send_idle_pct = 0;
      rcv_idle_pct <= 0;
      hold_arm <= ~hold_arm;
      repeat (12) send_req(gen_request());
      wait_drained();
      repeat (12) send_req(gen_request());
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lba28();
      test_directed_lba48();
      test_random_mix(100, 1'b0, 1'b0, 9, 65);
      test_random_mix(100, 1'b1, 1'b1, 65, 9);
      test_random_mix(100, 1'b1, 1'b0, 0, 0);
      test_backpressure();
      repeat (16) @(posedge clock);
      if (errors == 0 && ata_items_due.size() == 0) begin
         $display("status: pass");
      end else begin
         if (ata_items_due.size() != 0)
            $display("%0t: items left expected 0 actual %0d", $time, ata_items_due.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/asrs_pkg.sv
sv/asrs_queue.sv
sv/asrs_front.sv
sv/asrs_back.sv
sv/ata_sector_request_sequencer_unit.sv
bench/tb_ata_sector_request_sequencer_unit.sv
